@@ src/pwr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, codes and helpers of the wavetable resampler.
package pwr_pkg;

	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 12;
	localparam int DATA_W   = 18;
	localparam int INC_W    = 40;
	localparam int OUT_W    = 24;
	localparam int CNT_W    = 13;
	localparam int POS_W    = 44;
	localparam int INT_W    = POS_W - 32;
	localparam int FRAC_W   = 26;
	localparam int PHASE_W  = 6;
	localparam int PHASES   = 64;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int DOT_W    = 42;
	localparam int DIFF_W   = DOT_W + 1;
	localparam int IACC_W   = 72;
	localparam int PART_N   = 6;
	localparam int RND_SHIFT = 37;

	localparam logic [CMD_W-1:0] CMD_LOAD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_COEF   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK        = 2'd2;

	localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

	localparam logic [1:0] K_DOT0 = 2'd0;
	localparam logic [1:0] K_DOT1 = 2'd1;
	localparam logic [1:0] K_DIFF = 2'd2;
	localparam logic [1:0] K_PART = 2'd3;

	localparam logic signed [IACC_W-1:0] RND_BIAS = 72'sh10_0000_0000;
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = 24'sh7F_FFFF;
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = -24'sh80_0000;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic       first;
		logic [2:0] part;
	} ctl_t;

	typedef struct packed {
		logic                     sample_we;
		logic                     coef_we;
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] data;
	} mem_wr_t;

	function automatic logic [5:0] part_shift(input logic [2:0] part);
		logic [5:0] sh;
		case (part)
			3'd0: sh = 6'd0;
			3'd1: sh = 6'd13;
			3'd2: sh = 6'd17;
			3'd3: sh = 6'd30;
			3'd4: sh = 6'd34;
			3'd5: sh = 6'd47;
			default: sh = 6'd0;
		endcase
		return sh;
	endfunction

endpackage

@@ src/pwr_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the wavetable resampler.
interface pwr_item_if import pwr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [ADDR_W-1:0]        address;
	logic signed [DATA_W-1:0] load_value;
	logic [INC_W-1:0]         phase_increment;

	modport source(output valid, cmd, address, load_value, phase_increment, input ready);
	modport sink(input valid, cmd, address, load_value, phase_increment, output ready);
endinterface

interface pwr_result_if import pwr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sample_out;

	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface

interface pwr_cfg_if import pwr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ src/polyphase_wavetable_resampler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the polyphase wavetable resampler.
//
//  channel  role   payload
//  item     sink   cmd, address, load_value, phase_increment
//  result   source sample_out
//  cfg      sink   data (sample_count)
//
// A load request with an in-range address is written as it is accepted. A tick runs a wrap
// step and 13 modulo steps, then 2*TAPS taps, one difference and six partial products on
// the single shared multiplier, draining the MAC pipeline after each of those three phases.
// item.ready is low while a tick runs; a finished tick waits in its last state while the
// output register is still full. No clearing pass after reset; cfg is always ready.
module polyphase_wavetable_resampler_unit import pwr_pkg::*; #(
	parameter int TAPS = 16,
	parameter int SAMPLE_DEPTH = 4096,
	localparam int COEF_DEPTH = (PHASES + 1) * TAPS,
	localparam int CAW = $clog2(COEF_DEPTH)
) (
	input  logic        clk,
	input  logic        arst_n,
	pwr_item_if.sink    item,
	pwr_result_if.source result,
	pwr_cfg_if.sink     cfg
);

	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_data_q;

	mem_wr_t                  wr;
	logic                     rd_en;
	logic [CNT_W-1:0]         s_idx;
	logic [CAW-1:0]           c_addr;
	logic signed [DATA_W-1:0] s_data_s1;
	logic signed [DATA_W-1:0] c_data_s1;
	ctl_t                     ctl;
	logic [FRAC_W-1:0]        frac;
	logic                     busy;
	logic                     out_free;
	logic                     out_load;
	logic signed [OUT_W-1:0]  res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	pwr_seq #(
		.TAPS(TAPS),
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.count(count_q),
		.busy(busy),
		.out_free(out_free),
		.wr(wr),
		.rd_en(rd_en),
		.s_idx(s_idx),
		.c_addr(c_addr),
		.ctl(ctl),
		.frac(frac),
		.out_load(out_load)
	);

	pwr_mem #(
		.TAPS(TAPS),
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_mem (
		.clk(clk),
		.wr(wr),
		.rd_en(rd_en),
		.s_idx(s_idx),
		.c_addr(c_addr),
		.s_data_s1(s_data_s1),
		.c_data_s1(c_data_s1)
	);

	pwr_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.s_data_s1(s_data_s1),
		.c_data_s1(c_data_s1),
		.frac(frac),
		.busy(busy),
		.res(res)
	);

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;

endmodule

@@ src/pwr_mem.sv @@
`timescale 1ns / 1ps
// Sample and coefficient stores with one write and one registered read each.
module pwr_mem import pwr_pkg::*; #(
	parameter int TAPS = 16,
	parameter int SAMPLE_DEPTH = 4096,
	localparam int COEF_DEPTH = (PHASES + 1) * TAPS,
	localparam int CAW = $clog2(COEF_DEPTH)
) (
	input  logic                     clk,
	input  mem_wr_t                  wr,
	input  logic                     rd_en,
	input  logic [CNT_W-1:0]         s_idx,
	input  logic [CAW-1:0]           c_addr,
	output logic signed [DATA_W-1:0] s_data_s1,
	output logic signed [DATA_W-1:0] c_data_s1
);

	localparam int AW = $clog2(SAMPLE_DEPTH);

	logic signed [DATA_W-1:0] sample_mem [SAMPLE_DEPTH];
	logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.sample_we) begin
			sample_mem[AW'(wr.addr)] <= wr.data;
		end
		if (rd_en) begin
			s_data_s1 <= sample_mem[AW'(s_idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.coef_we) begin
			coef_mem[CAW'(wr.addr)] <= wr.data;
		end
		if (rd_en) begin
			c_data_s1 <= coef_mem[c_addr];
		end
	end

endmodule

@@ src/pwr_mac.sv @@
`timescale 1ns / 1ps
// Shared 18x18 multiplier with dot-product, difference and interpolation accumulators.
module pwr_mac import pwr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  logic signed [DATA_W-1:0] s_data_s1,
	input  logic signed [DATA_W-1:0] c_data_s1,
	input  logic [FRAC_W-1:0]        frac,
	output logic                     busy,
	output logic signed [OUT_W-1:0]  res
);

	ctl_t                     ctl_s1;
	ctl_t                     ctl_s2;
	logic signed [DATA_W-1:0] op_a;
	logic signed [DATA_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DOT_W-1:0]  acc0_q;
	logic signed [DOT_W-1:0]  acc1_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [IACC_W-1:0] iacc_q;
	logic [DOT_W-1:0]         prod_dot;
	logic [IACC_W-1:0]        prod_pp;
	logic signed [IACC_W-1:0] rsum;
	logic signed [IACC_W-RND_SHIFT-1:0] rq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	assign busy = ctl_s1.valid | ctl_s2.valid;

	always_comb begin
		op_a = s_data_s1;
		op_b = c_data_s1;
		if (ctl_s1.kind == K_PART) begin
			case (ctl_s1.part[2:1])
				2'd0: op_a = $signed({1'b0, diff_q[16:0]});
				2'd1: op_a = $signed({1'b0, diff_q[33:17]});
				default: op_a = $signed({{9{diff_q[DIFF_W-1]}}, diff_q[DIFF_W-1:34]});
			endcase
			if (ctl_s1.part[0]) begin
				op_b = $signed({5'b0, frac[25:13]});
			end else begin
				op_b = $signed({5'b0, frac[12:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
	end

	assign prod_dot = {{(DOT_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign prod_pp  = {{(IACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2} << part_shift(ctl_s2.part);

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			case (ctl_s2.kind)
				K_DOT0: acc0_q <= (ctl_s2.first ? '0 : acc0_q) + prod_dot;
				K_DOT1: acc1_q <= (ctl_s2.first ? '0 : acc1_q) + prod_dot;
				K_DIFF: begin
					diff_q <= {acc1_q[DOT_W-1], acc1_q} - {acc0_q[DOT_W-1], acc0_q};
					iacc_q <= {{(IACC_W-DOT_W){acc0_q[DOT_W-1]}}, acc0_q} << FRAC_W;
				end
				default: iacc_q <= iacc_q + prod_pp;
			endcase
		end
	end

	// round half up, then clamp to the output range
	assign rsum = iacc_q + RND_BIAS;
	assign rq   = $signed(rsum[IACC_W-1:RND_SHIFT]);

	always_comb begin
		if (rq > OUT_MAX) begin
			res = OUT_MAX;
		end else if (rq < OUT_MIN) begin
			res = OUT_MIN;
		end else begin
			res = $signed(rq[OUT_W-1:0]);
		end
	end

`ifndef SYNTHESIS
	a_part_after_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && ctl_s1.kind == K_PART) |-> !(ctl_s2.valid && ctl_s2.kind == K_DIFF))
		else $error("partial product read the difference before it was written");
`endif

endmodule

@@ src/pwr_seq.sv @@
`timescale 1ns / 1ps
// Request sequencer: loads, position wrap, address modulo and MAC operation issue.
module pwr_seq import pwr_pkg::*; #(
	parameter int TAPS = 16,
	parameter int SAMPLE_DEPTH = 4096,
	localparam int COEF_DEPTH = (PHASES + 1) * TAPS,
	localparam int CAW = $clog2(COEF_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	pwr_item_if.sink          item,
	input  logic [CNT_W-1:0]  count,
	input  logic              busy,
	input  logic              out_free,
	output mem_wr_t           wr,
	output logic              rd_en,
	output logic [CNT_W-1:0]  s_idx,
	output logic [CAW-1:0]    c_addr,
	output ctl_t              ctl,
	output logic [FRAC_W-1:0] frac,
	output logic              out_load
);

	localparam int KW = $clog2(2 * TAPS);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_WRAP      = 4'd1;
	localparam logic [3:0] ST_MOD       = 4'd2;
	localparam logic [3:0] ST_DOT       = 4'd3;
	localparam logic [3:0] ST_WAIT_DOT  = 4'd4;
	localparam logic [3:0] ST_DIFF      = 4'd5;
	localparam logic [3:0] ST_WAIT_DIFF = 4'd6;
	localparam logic [3:0] ST_PART      = 4'd7;
	localparam logic [3:0] ST_WAIT_PART = 4'd8;
	localparam logic [3:0] ST_OUT       = 4'd9;

	logic [3:0]        state_q;
	logic [POS_W-1:0]  pos_q;
	logic [KW-1:0]     k_q;
	logic [3:0]        cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [FRAC_W-1:0] frac_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  top_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CAW-1:0]    caddr_q;

	logic              accept;
	logic              tick;
	logic [CNT_W-1:0]  n_clamp;
	logic [CNT_W-1:0]  wrap_at;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_nx;
	logic [CNT_W-1:0]  idx_nx;
	logic              mod_last;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign tick       = accept && (item.cmd == CMD_TICK);

	always_comb begin
		n_clamp = count;
		if (32'(count) < TAPS) begin
			n_clamp = CNT_W'(TAPS);
		end else if (32'(count) > SAMPLE_DEPTH) begin
			n_clamp = CNT_W'(SAMPLE_DEPTH);
		end
	end

	assign wrap_at  = n_q - CNT_W'(TAPS - 1);
	assign rem_sh   = {rem_q, div_q[CNT_W-1]};
	assign rem_nx   = (rem_sh >= {1'b0, n_q}) ? rem_sh - {1'b0, n_q} : rem_sh;
	assign mod_last = (cnt_q == 4'(CNT_W - 1));

	always_comb begin
		if (k_q == KW'(TAPS - 1)) begin
			idx_nx = top_q;
		end else if (idx_q == '0) begin
			idx_nx = n_q - CNT_W'(1);
		end else begin
			idx_nx = idx_q - CNT_W'(1);
		end
	end

	assign wr.sample_we = accept && (item.cmd == CMD_LOAD_SAMPLE)
		&& (32'(item.address) < SAMPLE_DEPTH);
	assign wr.coef_we   = accept && (item.cmd == CMD_LOAD_COEF)
		&& (32'(item.address) < COEF_DEPTH);
	assign wr.addr      = item.address;
	assign wr.data      = item.load_value;

	assign rd_en    = (state_q == ST_DOT);
	assign s_idx    = idx_q;
	assign c_addr   = caddr_q;
	assign frac     = frac_q;
	assign out_load = (state_q == ST_OUT) && out_free;

	always_comb begin
		ctl.valid = 1'b0;
		ctl.kind  = K_DOT0;
		ctl.first = (k_q == '0) || (k_q == KW'(TAPS));
		ctl.part  = cnt_q[2:0];
		unique case (state_q)
			ST_DOT: begin
				ctl.valid = 1'b1;
				ctl.kind  = (k_q < KW'(TAPS)) ? K_DOT0 : K_DOT1;
			end
			ST_DIFF: begin
				ctl.valid = 1'b1;
				ctl.kind  = K_DIFF;
			end
			ST_PART: begin
				ctl.valid = 1'b1;
				ctl.kind  = K_PART;
			end
			default: ctl.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick) begin
						pos_q   <= pos_q + POS_W'(item.phase_increment);
						k_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if ({1'b0, pos_q[POS_W-1:32]} >= wrap_at) begin
						pos_q[POS_W-1:32] <= pos_q[POS_W-1:32] - INT_W'(wrap_at);
					end
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					cnt_q <= cnt_q + 4'd1;
					if (mod_last) begin
						cnt_q   <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(2 * TAPS - 1)) begin
						state_q <= ST_WAIT_DOT;
					end
				end
				ST_WAIT_DOT: begin
					if (!busy) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_WAIT_DIFF;
				ST_WAIT_DIFF: begin
					if (!busy) begin
						state_q <= ST_PART;
					end
				end
				ST_PART: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(PART_N - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_WAIT_PART;
					end
				end
				ST_WAIT_PART: begin
					if (!busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			n_q     <= n_clamp;
			frac_q  <= pos_q[FRAC_W-1:0];
			caddr_q <= CAW'(32'(pos_q[31:FRAC_W]) * TAPS);
			div_q   <= CNT_W'(pos_q[POS_W-1:32]) + CNT_W'(TAPS - 1);
			rem_q   <= '0;
		end
		if (state_q == ST_MOD) begin
			rem_q <= CNT_W'(rem_nx);
			div_q <= div_q << 1;
			if (mod_last) begin
				top_q <= CNT_W'(rem_nx);
				idx_q <= CNT_W'(rem_nx);
			end
		end
		if (state_q == ST_DOT) begin
			caddr_q <= caddr_q + CAW'(1);
			idx_q   <= idx_nx;
		end
	end

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !busy)
		else $error("MAC pipeline still busy in idle");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (rem_q < n_q))
		else $error("modulo remainder out of range");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOT) |-> (top_q < n_q) && (idx_q < n_q))
		else $error("sample index beyond wavetable length");
`endif

endmodule
